>>> src/rtp_pkg.sv
// Package for the raster thinning pass: side-length limits and the
// neighborhood keep table built at elaboration. No dependencies.
package rtp_pkg;

    localparam int MAX_SIDE_DEF = 64;
    localparam int SIDE_MIN     = 3;
    localparam int SIDE_RESET   = 64;
    localparam int SIDE_W       = 7;

    localparam int WALK_OUT = 0;
    localparam int WALK_IN  = 1;
    localparam int WALK_GAP = 2;

    // Neighbor bit k: 0 NW, 1 N, 2 NE, 3 E, 4 SE, 5 S, 6 SW, 7 W.
    // Entry is 1 when a set center pixel with that neighborhood stays set.
    function automatic logic [255:0] build_keep_table();
        logic [255:0] tbl;
        logic [7:0]   nb;
        logic         v;
        logic         done;
        int           code;
        int           k;
        int           cnt;
        int           first;
        int           mode;
        int           cuts;
        tbl = '0;
        for (code = 0; code < 256; code++) begin
            nb  = 8'(code);
            cnt = 0;
            for (k = 0; k < 8; k++) begin
                cnt = cnt + int'(nb[k]);
            end
            if (cnt >= 7) begin
                tbl[code] = 1'b0;
            end else if (cnt < 2) begin
                tbl[code] = 1'b1;
            end else begin
                first = -1;
                mode  = WALK_OUT;
                cuts  = 0;
                done  = 1'b0;
                for (k = 0; k < 16; k++) begin
                    if (!done) begin
                        v = nb[k % 8];
                        if (mode == WALK_OUT) begin
                            if (v) begin
                                if (first == -1) begin
                                    first = k;
                                end
                                mode = WALK_IN;
                            end
                        end else if (mode == WALK_IN) begin
                            if (!v) begin
                                mode = WALK_GAP;
                            end
                        end else begin
                            if (v) begin
                                if (k % 2 == 1) begin
                                    mode = WALK_IN;
                                end else begin
                                    mode = WALK_OUT;
                                    cuts = cuts + 1;
                                end
                            end else begin
                                mode = WALK_OUT;
                                cuts = cuts + 1;
                            end
                        end
                        if (k >= 8 && (k - 8) >= first) begin
                            done = 1'b1;
                        end
                    end
                end
                tbl[code] = (cuts <= 1) ? 1'b0 : 1'b1;
            end
        end
        return tbl;
    endfunction

    localparam logic [255:0] KEEP_TABLE = build_keep_table();

endpackage

>>> src/raster_thinning_pass.sv
// Top level of the raster thinning pass: input handshake, line buffers,
// 3x3 window, decision and output register. Depends on rtp_pkg.
//
// One item is accepted per clock whenever the output register is empty or
// being drained in the same cycle; an item that decides a pixel puts its
// result in the output register at the edge that accepts it. For side n,
// the first n+1 items of an image give no result, then each item gives the
// decision for the next pixel in raster order; the host closes each image
// with n+1 flush items. Two single-bit line buffers of MAX_SIDE entries
// (original pixels delayed n items, decided pixels delayed n-1 decisions)
// feed fixed window registers; there is no clearing pass, since image
// borders mask every tap not yet written. Writing the side register
// restarts the image.
module raster_thinning_pass #(
    parameter int MAX_SIDE = rtp_pkg::MAX_SIDE_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [rtp_pkg::SIDE_W-1:0] cfg_wdata,      // side_length
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [0] pixel_in, [7:1] zero
    input  logic [0:0]                 s_axis_tuser,   // [0] pad
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [15:0]                m_axis_tdata,   // [0] pixel_out, [6:1] out_row,
                                                       // [12:7] out_col, [15:13] zero
    output logic                       m_axis_tlast    // out_last
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int RW = $clog2(MAX_SIDE + 2);
    localparam int RESET_SIDE = (rtp_pkg::SIDE_RESET > MAX_SIDE) ? MAX_SIDE
                                                                 : rtp_pkg::SIDE_RESET;

    logic [CW-1:0] last_idx_reg, last_idx_next;
    logic [RW-1:0] arr_row_reg, arr_row_next;
    logic [CW-1:0] arr_col_reg, arr_col_next;
    logic [CW-1:0] dec_row_reg, dec_row_next;
    logic [CW-1:0] dec_col_reg, dec_col_next;
    logic          started_reg, started_next;
    logic [CW-1:0] optr_reg, optr_next;
    logic [CW-1:0] dptr_reg, dptr_next;
    logic          m_valid_reg, m_valid_next;

    logic          orig_mem_reg [MAX_SIDE];
    logic          dec_mem_reg  [MAX_SIDE];
    logic          orig_n_reg;
    logic          orig_n1_reg;
    logic          orig_1_reg;
    logic          orig_2_reg;
    logic          dec_nm1_reg;
    logic          dec_n_reg;
    logic          dec_n1_reg;
    logic          dec_1_reg;

    logic          pix_out_reg;
    logic [5:0]    row_out_reg;
    logic [5:0]    col_out_reg;
    logic          last_out_reg;

    logic          in_fire;
    logic          decide;
    logic          last_dec;
    logic          in_pixels;
    logic          pix_v;
    logic          at_top;
    logic          at_bot;
    logic          at_lft;
    logic          at_rgt;
    logic [7:0]    nb;
    logic          dec_val;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign decide        = in_fire && started_reg;
    assign last_dec      = (dec_row_reg == last_idx_reg) && (dec_col_reg == last_idx_reg);
    assign in_pixels     = arr_row_reg <= RW'(last_idx_reg);
    assign pix_v         = s_axis_tdata[0] && !s_axis_tuser[0] && in_pixels;

    assign at_top = dec_row_reg == '0;
    assign at_bot = dec_row_reg == last_idx_reg;
    assign at_lft = dec_col_reg == '0;
    assign at_rgt = dec_col_reg == last_idx_reg;

    assign nb[0] = dec_n1_reg  && !at_top && !at_lft;
    assign nb[1] = dec_n_reg   && !at_top;
    assign nb[2] = dec_nm1_reg && !at_top && !at_rgt;
    assign nb[3] = orig_n_reg  && !at_rgt;
    assign nb[4] = pix_v       && !at_bot && !at_rgt;
    assign nb[5] = orig_1_reg  && !at_bot;
    assign nb[6] = orig_2_reg  && !at_bot && !at_lft;
    assign nb[7] = dec_1_reg   && !at_lft;

    assign dec_val = orig_n1_reg && rtp_pkg::KEEP_TABLE[nb];

    always_comb begin
        int unsigned side_req;
        side_req      = 32'(cfg_wdata);
        last_idx_next = last_idx_reg;
        arr_row_next  = arr_row_reg;
        arr_col_next  = arr_col_reg;
        dec_row_next  = dec_row_reg;
        dec_col_next  = dec_col_reg;
        started_next  = started_reg;
        optr_next     = optr_reg;
        dptr_next     = dptr_reg;
        if (decide) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
        if (cfg_we) begin
            if (side_req < 32'(rtp_pkg::SIDE_MIN)) begin
                side_req = 32'(rtp_pkg::SIDE_MIN);
            end
            if (side_req > 32'(MAX_SIDE)) begin
                side_req = 32'(MAX_SIDE);
            end
            last_idx_next = CW'(side_req - 32'd1);
            arr_row_next  = '0;
            arr_col_next  = '0;
            dec_row_next  = '0;
            dec_col_next  = '0;
            started_next  = 1'b0;
            optr_next     = '0;
            dptr_next     = '0;
        end else if (in_fire) begin
            optr_next = (optr_reg == last_idx_reg - CW'(1)) ? '0 : optr_reg + CW'(1);
            if (decide) begin
                dptr_next = (dptr_reg == last_idx_reg - CW'(2)) ? '0 : dptr_reg + CW'(1);
            end
            if (decide && last_dec) begin
                arr_row_next = '0;
                arr_col_next = '0;
                dec_row_next = '0;
                dec_col_next = '0;
                started_next = 1'b0;
            end else begin
                if (arr_col_reg == last_idx_reg) begin
                    arr_col_next = '0;
                    arr_row_next = arr_row_reg + RW'(1);
                end else begin
                    arr_col_next = arr_col_reg + CW'(1);
                end
                if (decide) begin
                    if (dec_col_reg == last_idx_reg) begin
                        dec_col_next = '0;
                        dec_row_next = dec_row_reg + CW'(1);
                    end else begin
                        dec_col_next = dec_col_reg + CW'(1);
                    end
                end
                if (arr_row_reg == RW'(1) && arr_col_reg == '0) begin
                    started_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_idx_reg <= CW'(RESET_SIDE - 1);
            arr_row_reg  <= '0;
            arr_col_reg  <= '0;
            dec_row_reg  <= '0;
            dec_col_reg  <= '0;
            started_reg  <= 1'b0;
            optr_reg     <= '0;
            dptr_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            last_idx_reg <= last_idx_next;
            arr_row_reg  <= arr_row_next;
            arr_col_reg  <= arr_col_next;
            dec_row_reg  <= dec_row_next;
            dec_col_reg  <= dec_col_next;
            started_reg  <= started_next;
            optr_reg     <= optr_next;
            dptr_reg     <= dptr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            orig_mem_reg[optr_reg] <= pix_v;
            orig_n_reg             <= orig_mem_reg[optr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (decide) begin
            dec_mem_reg[dptr_reg] <= dec_val;
            dec_nm1_reg           <= dec_mem_reg[dptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            orig_1_reg  <= pix_v;
            orig_2_reg  <= orig_1_reg;
            orig_n1_reg <= orig_n_reg;
        end
        if (decide) begin
            dec_1_reg    <= dec_val;
            dec_n_reg    <= dec_nm1_reg;
            dec_n1_reg   <= dec_n_reg;
            pix_out_reg  <= dec_val;
            row_out_reg  <= 6'(dec_row_reg);
            col_out_reg  <= 6'(dec_col_reg);
            last_out_reg <= last_dec;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, col_out_reg, row_out_reg, pix_out_reg};
    assign m_axis_tlast  = last_out_reg;

    a_started_row : assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |-> arr_row_reg != '0)
        else $error("decision phase active in first arrival row");

    a_decide_out : assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && started_reg |=> m_valid_reg)
        else $error("deciding item left no result");

    a_lag : assert property (@(posedge aclk) disable iff (!aresetn)
        started_reg |->
            (arr_row_reg == RW'(dec_row_reg) + RW'(1) && arr_col_reg == dec_col_reg + CW'(1))
            || (dec_col_reg == last_idx_reg && arr_col_reg == '0
                && arr_row_reg == RW'(dec_row_reg) + RW'(2)))
        else $error("decide position not side+1 behind arrival");

endmodule
